// File: hw/rtl/upd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int unsigned DefQueueDepth = 4;

  // one decoded step: up to three output words sharing one malformed flag
  typedef struct packed {
    logic [1:0]      cnt;
    logic            mal;
    logic [2:0][7:0] bytes;
  } upd_cmd_t;

  function automatic logic hex_valid(input logic [7:0] c);
    hex_valid = ((c >= 8'h30) && (c <= 8'h39)) ||
                ((c >= 8'h41) && (c <= 8'h46)) ||
                ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/upd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_front
// Accepts input words, tracks the escape phase and emits decode commands.
// ----------------------------------------------------------------------------
module upd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             op_i,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output upd_pkg::upd_cmd_t     cmd_o
);
  import upd_pkg::*;

  localparam logic [1:0] PhNormal = 2'd0;
  localparam logic [1:0] PhPct    = 2'd1;
  localparam logic [1:0] PhDigit  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       has_cmd;
  logic       accept;
  upd_cmd_t   cmd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_cmd;
  assign cmd_o      = cmd;

  always_comb begin
    cmd     = '0;
    has_cmd = 1'b0;
    phase_d = phase_q;
    held_d  = held_q;
    if (op_i) begin
      phase_d = PhNormal;
      unique case (phase_q)
        PhPct: begin
          has_cmd      = 1'b1;
          cmd.cnt      = 2'd1;
          cmd.mal      = 1'b1;
          cmd.bytes[0] = ChPercent;
        end
        PhDigit: begin
          has_cmd      = 1'b1;
          cmd.cnt      = 2'd2;
          cmd.mal      = 1'b1;
          cmd.bytes[0] = ChPercent;
          cmd.bytes[1] = held_q;
        end
        default: begin
          has_cmd = 1'b0;
        end
      endcase
    end else begin
      unique case (phase_q)
        PhPct: begin
          if (hex_valid(in_byte_i)) begin
            held_d  = in_byte_i;
            phase_d = PhDigit;
          end else begin
            has_cmd      = 1'b1;
            cmd.cnt      = 2'd2;
            cmd.mal      = 1'b1;
            cmd.bytes[0] = ChPercent;
            cmd.bytes[1] = in_byte_i;
            phase_d      = PhNormal;
          end
        end
        PhDigit: begin
          has_cmd = 1'b1;
          phase_d = PhNormal;
          if (hex_valid(in_byte_i)) begin
            cmd.cnt      = 2'd1;
            cmd.mal      = 1'b0;
            cmd.bytes[0] = {hex_nibble(held_q), hex_nibble(in_byte_i)};
          end else begin
            cmd.cnt      = 2'd3;
            cmd.mal      = 1'b1;
            cmd.bytes[0] = ChPercent;
            cmd.bytes[1] = held_q;
            cmd.bytes[2] = in_byte_i;
          end
        end
        default: begin
          phase_d = PhNormal;
          if (in_byte_i == ChPercent) begin
            phase_d = PhPct;
          end else begin
            has_cmd      = 1'b1;
            cmd.cnt      = 2'd1;
            cmd.mal      = 1'b0;
            cmd.bytes[0] = (in_byte_i == ChPlus) ? ChSpace : in_byte_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/upd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_queue
// Small command queue between the front and back parts of the decoder.
// ----------------------------------------------------------------------------
module upd_queue #(
  parameter int unsigned Depth = upd_pkg::DefQueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire upd_pkg::upd_cmd_t wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output upd_pkg::upd_cmd_t      rdata_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  upd_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/upd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_back
// Expands queued commands into output words through an output register.
// ----------------------------------------------------------------------------
module upd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire upd_pkg::upd_cmd_t cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   malformed_o,
  output logic                   last_o
);
  import upd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       mal_q, last_q;
  logic       load;
  logic       is_last;

  assign load    = cmd_valid_i && (!valid_q || out_ready_i);
  assign is_last = (idx_q == (cmd_i.cnt - 2'd1));
  assign pop_o   = load && is_last;
  assign idx_d   = is_last ? 2'd0 : idx_q + 2'd1;

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign malformed_o = mal_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cmd_i.bytes[idx_q];
      mal_q  <= cmd_i.mal;
      last_q <= is_last;
    end
  end

  // word index stays inside the head command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q < cmd_i.cnt))
    else $error("word index beyond command length");

  // index rests at zero between commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> (idx_q == 2'd0))
    else $error("word index not cleared while queue empty");

  // a popped command always leaves a last word behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q))
    else $error("command popped without last word");

  // a held word is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> ($stable(byte_q) && $stable(last_q) && valid_q))
    else $error("stalled output word changed");

endmodule

`default_nettype wire

// File: hw/rtl/url_percent_decoder_stream_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder_stream_core
// Streaming URL percent decoder, one byte word in, zero to three words out.
//
// Input stream: s_axis_tdata carries the raw byte, s_axis_tuser marks end of
// stream (flush of a pending escape). Output stream: m_axis_tdata is the
// decoded byte, m_axis_tuser flags bytes from a broken or unfinished escape,
// m_axis_tlast marks the final word produced by one input word.
// A front stage classifies each input word and tracks the escape phase; it
// pushes one command per productive word into a queue of QueueDepth entries.
// A back stage expands each command into its words through an output
// register, fed from the queue head. Throughput is one input word per cycle
// while the queue has room; the output moves one word per cycle while the
// receiver accepts, so a command with k words holds the back stage for k
// words. When the receiver stalls, the output word holds and the
// queue absorbs up to QueueDepth commands before s_axis_tready drops.
// Reset clears the escape phase, the queue and the output valid.
// ----------------------------------------------------------------------------
module url_percent_decoder_stream_core #(
  parameter int unsigned QueueDepth = upd_pkg::DefQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte
  input  wire logic       s_axis_tuser,   // op
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic            m_axis_tuser,   // malformed
  output logic            m_axis_tlast
);
  import upd_pkg::*;

  logic     push, full, pop, cmd_valid;
  upd_cmd_t wcmd, rcmd;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (wcmd)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wcmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .rdata_o (rcmd)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (rcmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .malformed_o (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire
